// ===== sv/esbd_pkg.sv =====
package esbd_pkg;

    localparam int unsigned DAYS_W = 16;           // up to 46844 days
    localparam int unsigned SOD_W  = 17;           // up to 115443 s within a day
    localparam int unsigned ABS_W  = 33;           // absolute seconds, with headroom
    localparam int unsigned OUT_W  = 32;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [3:0]  MONTH_MARCH   = 4'd3;

    typedef struct packed {
        logic [6:0] start_year;
        logic [3:0] start_month;
        logic [4:0] start_day;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [5:0] start_second;
        logic [6:0] now_year;
        logic [3:0] now_month;
        logic [4:0] now_day;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
    } t_in;

    typedef struct packed {
        logic [31:0] elapsed_seconds;
        logic        now_before_start;
    } t_out;

    // One timestamp split into whole days since 2000 and seconds within the day.
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
    } t_stamp;

    typedef struct packed {
        t_stamp start;
        t_stamp now;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Days in the whole months before month m, common year.
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            4'd13:   d = 9'd365;
            4'd14:   d = 9'd395;
            default: d = 9'd425;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/esbd_front.sv =====
module esbd_front import esbd_pkg::*; (
    input  logic   i_valid,
    input  t_in    i_data,
    input  logic   i_q_full,
    output logic   o_stall,
    output logic   o_push,
    output t_entry o_entry
);

    // Map one timestamp to day count and second-of-day.
    function automatic t_stamp to_stamp(input logic [6:0] yr, input logic [3:0] mo,
                                        input logic [4:0] dy, input logic [4:0] hr,
                                        input logic [5:0] mi, input logic [5:0] se);
        t_stamp     s;
        logic [7:0] yr_p3;
        logic       leap;
        yr_p3  = {1'b0, yr} + 8'd3;
        leap   = (yr[1:0] == 2'b00);           // 2000 is divisible by 4
        s.days = DAYS_W'(yr) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(yr_p3[7:2])
               + DAYS_W'(days_before_month(mo))
               + DAYS_W'((leap && mo >= MONTH_MARCH) ? 1'b1 : 1'b0)
               + DAYS_W'(dy);
        s.sod  = SOD_W'(hr) * SOD_W'(SECS_PER_HOUR) + SOD_W'(mi) * SOD_W'(SECS_PER_MIN)
               + SOD_W'(se);
        return s;
    endfunction

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign o_entry.start = to_stamp(i_data.start_year, i_data.start_month, i_data.start_day,
                                    i_data.start_hour, i_data.start_minute,
                                    i_data.start_second);
    assign o_entry.now   = to_stamp(i_data.now_year, i_data.now_month, i_data.now_day,
                                    i_data.now_hour, i_data.now_minute, i_data.now_second);

endmodule

// ===== sv/esbd_queue.sv =====
module esbd_queue import esbd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_entry    o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);

endmodule

// ===== sv/esbd_back.sv =====
module esbd_back import esbd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_empty,
    input  t_entry i_head,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_stall,
    output t_out   o_data
);

    logic             r_s1_vld;
    logic [ABS_W-1:0] r_abs_start, r_abs_now;
    logic             r_out_vld;
    t_out             r_out, n_out;
    logic             out_adv, s1_adv;
    logic [ABS_W-1:0] diff;

    assign out_adv = !r_out_vld || !i_stall;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_pop   = !i_q_empty && s1_adv;

    // Stage 2: compare, subtract, saturate.
    always_comb begin
        diff  = r_abs_now - r_abs_start;
        n_out = '0;
        if (r_abs_now < r_abs_start) begin
            n_out.now_before_start = 1'b1;
        end else if (diff[ABS_W-1]) begin
            n_out.elapsed_seconds = '1;
        end else begin
            n_out.elapsed_seconds = diff[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_vld <= !i_q_empty;
            end
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // Stage 1: days * 86400 + second-of-day, one multiplier per timestamp.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_abs_start <= ABS_W'(i_head.start.days) * ABS_W'(SECS_PER_DAY)
                         + ABS_W'(i_head.start.sod);
            r_abs_now   <= ABS_W'(i_head.now.days) * ABS_W'(SECS_PER_DAY)
                         + ABS_W'(i_head.now.sod);
        end
        if (out_adv && r_s1_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

// ===== sv/elapsed_seconds_between_datetimes_top.sv =====
// Elapsed seconds between two datetimes (years 2000 onward, 4-year leap rule).
// Path: a beat goes into the queue, is registered by the multiply stage, then by the
//   output register. Throughput: one beat per cycle while the output is not stalled;
//   output stalls back up through the queue.
// Reset: synchronous active-low i_rst_n empties the queue and clears pipeline valids;
//   no clearing pass, the block takes beats the cycle after reset drops.
module elapsed_seconds_between_datetimes_top import esbd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4      // 2..16 entries
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // Front: converts both timestamps of a beat into day count plus
    // second-of-day (constant multiplies and the month table only).
    logic      push;
    t_entry    entry;
    // Queue: decouples front and back so either side can stall alone.
    t_q_status q_status;
    t_entry    head;
    logic      pop;

    esbd_front u_front (
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (q_status.full),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_entry  (entry)
    );

    esbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    // Back: days * 86400 registered, then difference with the
    // "now before start" flag into the output register.
    esbd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_status.empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule

// ===== dv/esbd_diff_monitor.sv =====
module esbd_diff_monitor
    import esbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_in  stamps;
        t_out want;
    } t_pending_diff;

    t_pending_diff pending_diffs[$];
    int            fails = 0;

    // Length of month m; months 13 and 14 run 30 days each.
    function automatic int month_len(input int m);
        case (m)
            2:                     return 28;
            4, 6, 9, 11, 13, 14:   return 30;
            default:               return 31;
        endcase
    endfunction

    // Seconds since 2000-01-01 00:00:00 (day fields used linearly, day 1 -> 1 day).
    function automatic logic [63:0] stamp_seconds(
        input logic [6:0] yr, input logic [3:0] mo, input logic [4:0] dy,
        input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] se
    );
        logic [63:0] days;
        days = 64'(yr) * 64'd365 + (64'(yr) + 64'd3) / 64'd4;
        for (int m = 1; m < int'(mo); m++) begin
            days += 64'(month_len(m));
        end
        // 2000 is a multiple of 4, so the leap test is on the low two bits
        if (yr[1:0] == 2'b00 && mo >= 4'd3) begin
            days += 64'd1;
        end
        days += 64'(dy);
        return days * 64'd86400 + 64'(hr) * 64'd3600 + 64'(mi) * 64'd60 + 64'(se);
    endfunction

    function automatic t_out elapsed_between(input t_in d);
        logic [63:0] t_from;
        logic [63:0] t_to;
        logic [63:0] diff;
        t_out        r;
        t_from = stamp_seconds(d.start_year, d.start_month, d.start_day,
                               d.start_hour, d.start_minute, d.start_second);
        t_to   = stamp_seconds(d.now_year, d.now_month, d.now_day,
                               d.now_hour, d.now_minute, d.now_second);
        if (t_to < t_from) begin
            r.elapsed_seconds  = '0;
            r.now_before_start = 1'b1;
        end else begin
            diff = t_to - t_from;
            r.elapsed_seconds  = (diff > 64'hFFFF_FFFF) ? '1 : diff[31:0];
            r.now_before_start = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pending_diff head;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                head.stamps = i_in_data;
                head.want   = elapsed_between(i_in_data);
                pending_diffs.push_back(head);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_diffs.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with nothing pending: elapsed=%0d flag=%0b",
                             $time, i_out_data.elapsed_seconds,
                             i_out_data.now_before_start);
                end else begin
                    head = pending_diffs.pop_front();
                    if (i_out_data.elapsed_seconds !== head.want.elapsed_seconds) begin
                        fails++;
                        $display("%0t: elapsed_seconds expected %0d got %0d (in %h)",
                                 $time, head.want.elapsed_seconds,
                                 i_out_data.elapsed_seconds, head.stamps);
                    end
                    if (i_out_data.now_before_start !== head.want.now_before_start) begin
                        fails++;
                        $display("%0t: now_before_start expected %0b got %0b (in %h)",
                                 $time, head.want.now_before_start,
                                 i_out_data.now_before_start, head.stamps);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_waiting    <= pending_diffs.size();
    end

endmodule

// ===== dv/elapsed_seconds_between_datetimes_top_tb.sv =====
module elapsed_seconds_between_datetimes_top_tb import esbd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // One timestamp; two of these back to back have the layout of t_in.
    typedef struct packed {
        logic [6:0] yr;
        logic [3:0] mo;
        logic [4:0] dy;
        logic [4:0] hr;
        logic [5:0] mi;
        logic [5:0] se;
    } t_moment;

    localparam int N_RANDOM       = 1450;
    localparam int QUIET_FIRST    = 600;   // window of back-to-back beats, no stalls
    localparam int QUIET_LAST     = 799;
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles; above the longest gap or stall

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    int fail_count;
    int diffs_waiting;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    always #2 i_clk = ~i_clk;

    elapsed_seconds_between_datetimes_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    esbd_diff_monitor u_diff_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_waiting    (diffs_waiting)
    );

    // Gap lengths: mostly none, some short, a few long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_moment mk(input int y, input int mo, input int d,
                                   input int h, input int mi, input int s);
        t_moment m;
        m.yr = 7'(y);
        m.mo = 4'(mo);
        m.dy = 5'(d);
        m.hr = 5'(h);
        m.mi = 6'(mi);
        m.se = 6'(s);
        return m;
    endfunction

    function automatic int month_days(input int mo, input int yr);
        case (mo)
            2:             return (yr % 4 == 0) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // A real calendar date in 2000..2099.
    function automatic t_moment any_moment();
        t_moment m;
        m.yr = 7'($urandom_range(0, 99));
        m.mo = 4'($urandom_range(1, 12));
        m.dy = 5'($urandom_range(1, month_days(m.mo, m.yr)));
        m.hr = 5'($urandom_range(0, 23));
        m.mi = 6'($urandom_range(0, 59));
        m.se = 6'($urandom_range(0, 59));
        return m;
    endfunction

    // Every bit of every field free, out-of-range values included.
    function automatic t_moment raw_moment();
        return t_moment'(33'({$urandom, $urandom}));
    endfunction

    // Same or later moment: one field pushed forward inside its range.
    function automatic t_moment later_than(input t_moment a);
        t_moment b;
        b = a;
        case ($urandom_range(0, 5))
            0: b.se = 6'($urandom_range(a.se, 59));
            1: b.mi = 6'($urandom_range(a.mi, 59));
            2: b.hr = 5'($urandom_range(a.hr, 23));
            3: b.dy = 5'($urandom_range(a.dy, 31));
            4: b.mo = 4'($urandom_range(a.mo, 12));
            default: b.yr = 7'($urandom_range(a.yr, 99));
        endcase
        return b;
    endfunction

    function automatic t_in next_random_beat();
        t_moment s;
        t_moment n;
        t_moment t;
        int      r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            // ordered pair of real dates, the common use
            s = any_moment();
            n = any_moment();
            if ({n} < {s}) begin
                t = s;
                s = n;
                n = t;
            end
        end else if (r < 65) begin
            s = any_moment();
            n = later_than(s);
        end else if (r < 80) begin
            // unordered: now may be earlier
            s = any_moment();
            n = any_moment();
        end else if (r < 90) begin
            // last second of a month against the first of the next (or itself), maybe swapped
            s = any_moment();
            s.dy = 5'(month_days(s.mo, s.yr));
            s.hr = 5'd23;
            s.mi = 6'd59;
            s.se = 6'd59;
            if ($urandom_range(0, 3) == 0) begin
                n = s;
            end else if (s.mo == 4'd12) begin
                n = mk(s.yr + 1, 1, 1, 0, 0, 0);
            end else begin
                n = mk(s.yr, s.mo + 1, 1, 0, 0, 0);
            end
            if ($urandom_range(0, 4) == 0) begin
                t = s;
                s = n;
                n = t;
            end
        end else begin
            s = raw_moment();
            n = raw_moment();
        end
        return t_in'({s, n});
    endfunction

    // Holds valid high across back-to-back beats; drops it only for a gap.
    task automatic send_beat(input t_in beat);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Result-side backpressure: alternating free and stalled runs of random length, none in the quiet window.
    initial begin
        forever begin
            i_stall <= 1'b0;
            repeat (1 + idle_len()) @(posedge i_clk);
            if (!quiet) begin
                i_stall <= 1'b1;
                repeat (1 + idle_len()) @(posedge i_clk);
            end
        end
    end

    // Watchdog: any accepted beat on either channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        t_in directed_beats[$];

        // corner pairs first
        directed_beats.push_back({mk(0, 1, 1, 0, 0, 0), mk(0, 1, 1, 0, 0, 0)});     // equal, origin
        directed_beats.push_back({mk(37, 6, 15, 12, 30, 30), mk(37, 6, 15, 12, 30, 30)});
        directed_beats.push_back({mk(37, 6, 15, 12, 30, 31), mk(37, 6, 15, 12, 30, 30)}); // 1 s early
        directed_beats.push_back({mk(0, 1, 1, 0, 0, 0), mk(99, 12, 31, 23, 59, 59)});  // full span
        directed_beats.push_back({mk(99, 12, 31, 23, 59, 59), mk(0, 1, 1, 0, 0, 0)});  // reversed
        directed_beats.push_back({mk(24, 2, 28, 23, 59, 59), mk(24, 3, 1, 0, 0, 0)});  // leap Feb
        directed_beats.push_back({mk(23, 2, 28, 23, 59, 59), mk(23, 3, 1, 0, 0, 0)});  // common Feb
        directed_beats.push_back({mk(24, 2, 29, 0, 0, 0), mk(24, 3, 1, 0, 0, 0)});
        directed_beats.push_back({mk(23, 12, 31, 23, 59, 59), mk(24, 1, 1, 0, 0, 0)}); // new year
        directed_beats.push_back({mk(0, 2, 29, 12, 0, 0), mk(1, 2, 28, 12, 0, 0)});    // year 2000
        directed_beats.push_back({mk(10, 1, 5, 0, 0, 0), mk(10, 0, 5, 0, 0, 0)});      // month zero
        directed_beats.push_back({mk(11, 1, 1, 0, 0, 0), mk(10, 13, 1, 0, 0, 0)});     // month 13
        directed_beats.push_back({mk(12, 1, 1, 0, 0, 0), mk(12, 14, 1, 0, 0, 0)});     // leap, 14
        directed_beats.push_back({mk(13, 1, 1, 0, 0, 0), mk(13, 15, 31, 0, 0, 0)});    // month 15
        directed_beats.push_back({mk(50, 7, 0, 0, 0, 0), mk(50, 7, 1, 0, 0, 0)});      // day zero
        directed_beats.push_back({mk(50, 7, 4, 0, 0, 0), mk(50, 7, 3, 31, 0, 0)});     // hour past 23
        directed_beats.push_back({mk(50, 7, 4, 0, 0, 0), mk(50, 7, 4, 0, 63, 63)});    // min/sec > 59
        directed_beats.push_back({mk(99, 12, 31, 23, 59, 59), mk(100, 1, 1, 0, 0, 0)}); // year 100
        directed_beats.push_back({mk(0, 0, 0, 0, 0, 0), mk(127, 15, 31, 31, 63, 63)}); // all ones
        directed_beats.push_back({mk(127, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0)});
        directed_beats.push_back({mk(124, 3, 1, 0, 0, 0), mk(124, 2, 29, 23, 59, 59)});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_beats[k]) begin
            send_beat(directed_beats[k]);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            quiet = (k >= QUIET_FIRST && k <= QUIET_LAST);
            send_beat(next_random_beat());
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        // the monitor's waiting count is a registered copy of its queue size
        @(posedge i_clk);
        while (diffs_waiting != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && diffs_waiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/esbd_pkg.sv
sv/esbd_front.sv
sv/esbd_queue.sv
sv/esbd_back.sv
sv/elapsed_seconds_between_datetimes_top.sv
dv/esbd_diff_monitor.sv
dv/elapsed_seconds_between_datetimes_top_tb.sv
